// ===== src/x86_64_instruction_byte_encoder_macros.svh =====
// Assertion macros shared by the x86 encoder checker.
`ifndef X86_64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH
`define X86_64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define X86ENC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define X86ENC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Holds at every edge sampled with reset asserted.
`define X86ENC_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge clk) !rst_n |-> (cons)) \
        else $error(msg);

`endif

// ===== src/x86enc_pkg.sv =====
// Types and encoding constants of the x86-64 instruction byte encoder.
`timescale 1ns / 1ps

package x86enc_pkg;

    localparam int TYPE_W     = 5;
    localparam int REG_W      = 4;
    localparam int IMM_W      = 64;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 5;
    localparam int LIST_BYTES = 10;
    localparam int MAX_BYTES  = 25;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PUSH     = 5'd0,
        REQ_POP      = 5'd1,
        REQ_RET      = 5'd2,
        REQ_ADD_IMM  = 5'd3,
        REQ_SUB_IMM  = 5'd4,
        REQ_MOV_RR   = 5'd5,
        REQ_XOR_RR   = 5'd6,
        REQ_ADD_RR   = 5'd7,
        REQ_SUB_RR   = 5'd8,
        REQ_MOV_IMM  = 5'd9,
        REQ_FLD      = 5'd10,
        REQ_FMUL     = 5'd11,
        REQ_FADD     = 5'd12,
        REQ_FSUB     = 5'd13,
        REQ_FSTP     = 5'd14,
        REQ_FLD1     = 5'd15,
        REQ_FLDZ     = 5'd16,
        REQ_PROLOGUE = 5'd17,
        REQ_EPILOGUE = 5'd18
    } req_kind_t;

    typedef enum logic [1:0] {
        MODE_LIST     = 2'd0,
        MODE_PROLOGUE = 2'd1,
        MODE_EPILOGUE = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                              mode;
        logic [CNT_W-1:0]                   len;
        logic [LIST_BYTES-1:0][BYTE_W-1:0]  bytes;
    } desc_t;

    localparam logic [BYTE_W-1:0] OP_REX_B      = 8'h41;
    localparam logic [BYTE_W-1:0] OP_REX_W      = 8'h48;
    localparam logic [BYTE_W-1:0] OP_PUSH       = 8'h50;
    localparam logic [BYTE_W-1:0] OP_POP        = 8'h58;
    localparam logic [BYTE_W-1:0] OP_RET        = 8'hC3;
    localparam logic [BYTE_W-1:0] OP_GRP1_IMM8  = 8'h83;
    localparam logic [BYTE_W-1:0] OP_GRP1_IMM32 = 8'h81;
    localparam logic [BYTE_W-1:0] OP_ADD_RAX    = 8'h05;
    localparam logic [BYTE_W-1:0] OP_SUB_RAX    = 8'h2D;
    localparam logic [BYTE_W-1:0] OP_MOV_RR     = 8'h89;
    localparam logic [BYTE_W-1:0] OP_XOR_RR     = 8'h31;
    localparam logic [BYTE_W-1:0] OP_ADD_RR     = 8'h01;
    localparam logic [BYTE_W-1:0] OP_SUB_RR     = 8'h29;
    localparam logic [BYTE_W-1:0] OP_MOV_IMM32  = 8'hC7;
    localparam logic [BYTE_W-1:0] OP_MOV_IMM64  = 8'hB8;
    localparam logic [BYTE_W-1:0] OP_FPU_DD     = 8'hDD;
    localparam logic [BYTE_W-1:0] OP_FPU_DC     = 8'hDC;
    localparam logic [BYTE_W-1:0] OP_FPU_D9     = 8'hD9;
    localparam logic [BYTE_W-1:0] MODRM_FLD1    = 8'hE8;
    localparam logic [BYTE_W-1:0] MODRM_FLDZ    = 8'hEE;
    localparam logic [BYTE_W-1:0] MODRM_REG     = 8'hC0;
    localparam logic [BYTE_W-1:0] MODRM_ADD     = 8'hC0;
    localparam logic [BYTE_W-1:0] MODRM_SUB     = 8'hE8;
    localparam logic [BYTE_W-1:0] MODRM_SIB     = 8'h04;
    localparam logic [BYTE_W-1:0] MODRM_DISP8   = 8'h45;
    localparam logic [BYTE_W-1:0] SIB_NO_INDEX  = 8'h24;
    localparam logic [BYTE_W-1:0] DISP8_ZERO    = 8'h00;

    localparam logic [2:0] EXT_FLD  = 3'd0;
    localparam logic [2:0] EXT_FMUL = 3'd1;
    localparam logic [2:0] EXT_FADD = 3'd0;
    localparam logic [2:0] EXT_FSUB = 3'd4;
    localparam logic [2:0] EXT_FSTP = 3'd3;

    localparam logic [2:0] REG_LOW_SP = 3'd4;
    localparam logic [2:0] REG_LOW_BP = 3'd5;

    localparam logic [CNT_W-1:0] PROLOGUE_LEN  = 5'd24;
    localparam logic [CNT_W-1:0] EPILOGUE_LEN  = 5'd25;
    localparam logic [CNT_W-1:0] LOW_REG_COUNT = 5'd8;
    localparam logic [CNT_W-1:0] EPI_PAIR_END  = 5'd16;
    localparam logic [CNT_W-1:0] EPI_RET_AT    = 5'd24;

endpackage

// ===== src/x86enc_req_if.sv =====
// Request channel: instruction kind, registers and immediate.
`timescale 1ns / 1ps

interface x86enc_req_if import x86enc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [TYPE_W-1:0]       req_type;
    logic [REG_W-1:0]        reg_a;
    logic [REG_W-1:0]        reg_b;
    logic signed [IMM_W-1:0] immediate;

    modport source (output valid, output req_type, output reg_a, output reg_b,
                    output immediate, input ready);
    modport sink   (input valid, input req_type, input reg_a, input reg_b,
                    input immediate, output ready);
endinterface

// ===== src/x86enc_beat_if.sv =====
// Result channel: one code byte per beat with count and last marker.
`timescale 1ns / 1ps

interface x86enc_beat_if import x86enc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic [CNT_W-1:0]  byte_count;
    logic              last;

    modport source (output valid, output code_byte, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input code_byte, input byte_count, input last,
                    output ready);
endinterface

// ===== src/x86enc_front.sv =====
// Front end: accepts requests and classifies them into byte descriptors.
`timescale 1ns / 1ps

module x86enc_front import x86enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    x86enc_req_if.sink  req,
    output desc_t       desc,
    output logic        desc_valid,
    input  logic        desc_ready
);

    desc_t desc_reg, desc_next;
    logic  desc_valid_reg, desc_valid_next;

    desc_t                             cls;
    logic [LIST_BYTES-1:0][BYTE_W-1:0] body;
    logic [CNT_W-1:0]                  body_len;
    logic                              pre;
    logic [2:0]                        low;
    logic                              rex_b;
    logic [31:0]                       lo;
    logic                              imm8_fit;
    logic                              imm32_fit;
    logic                              imm_zero;
    logic                              is_sub;
    logic [BYTE_W-1:0]                 op;
    logic [BYTE_W-1:0]                 modrm_base;
    logic [2:0]                        ext;
    logic                              accept;

    always_comb
    begin
        body       = '0;
        body_len   = '0;
        pre        = 1'b0;
        cls.mode   = MODE_LIST;
        low        = req.reg_a[2:0];
        rex_b      = req.reg_a[3];
        lo         = req.immediate[31:0];
        imm8_fit   = (&lo[31:7]) || !(|lo[31:7]);
        imm32_fit  = (&req.immediate[63:31]) || !(|req.immediate[63:31]);
        imm_zero   = (req.immediate == '0);
        is_sub     = (req.req_type == REQ_SUB_IMM);
        modrm_base = is_sub ? MODRM_SUB : MODRM_ADD;
        op         = '0;
        ext        = '0;

        case (req.req_type)
            REQ_PUSH:
            begin
                pre      = rex_b;
                body[0]  = OP_PUSH | {5'b0, low};
                body_len = 5'd1;
            end
            REQ_POP:
            begin
                pre      = rex_b;
                body[0]  = OP_POP | {5'b0, low};
                body_len = 5'd1;
            end
            REQ_RET:
            begin
                body[0]  = OP_RET;
                body_len = 5'd1;
            end
            REQ_ADD_IMM, REQ_SUB_IMM:
            begin
                body[0] = OP_REX_W | {7'b0, rex_b};
                if (imm8_fit)
                begin
                    body[1]  = OP_GRP1_IMM8;
                    body[2]  = modrm_base | {5'b0, low};
                    body[3]  = lo[7:0];
                    body_len = 5'd4;
                end
                else if (req.reg_a == '0)
                begin
                    body[1] = is_sub ? OP_SUB_RAX : OP_ADD_RAX;
                    for (int i = 0; i < 4; i++)
                    begin
                        body[2+i] = lo[8*i +: 8];
                    end
                    body_len = 5'd6;
                end
                else
                begin
                    body[1] = OP_GRP1_IMM32;
                    body[2] = modrm_base | {5'b0, low};
                    for (int i = 0; i < 4; i++)
                    begin
                        body[3+i] = lo[8*i +: 8];
                    end
                    body_len = 5'd7;
                end
            end
            REQ_MOV_RR, REQ_XOR_RR, REQ_ADD_RR, REQ_SUB_RR:
            begin
                case (req.req_type)
                    REQ_MOV_RR: op = OP_MOV_RR;
                    REQ_XOR_RR: op = OP_XOR_RR;
                    REQ_ADD_RR: op = OP_ADD_RR;
                    default:    op = OP_SUB_RR;
                endcase
                body[0]  = OP_REX_W | {5'b0, req.reg_b[3], 1'b0, rex_b};
                body[1]  = op;
                body[2]  = MODRM_REG | {2'b0, req.reg_b[2:0], low};
                body_len = 5'd3;
            end
            REQ_MOV_IMM:
            begin
                if (imm_zero)
                begin
                    body[0]  = OP_REX_W | {5'b0, rex_b, 1'b0, rex_b};
                    body[1]  = OP_XOR_RR;
                    body[2]  = MODRM_REG | {2'b0, low, low};
                    body_len = 5'd3;
                end
                else if (imm32_fit)
                begin
                    body[0] = OP_REX_W | {7'b0, rex_b};
                    body[1] = OP_MOV_IMM32;
                    body[2] = MODRM_REG | {5'b0, low};
                    for (int i = 0; i < 4; i++)
                    begin
                        body[3+i] = req.immediate[8*i +: 8];
                    end
                    body_len = 5'd7;
                end
                else
                begin
                    body[0] = OP_REX_W | {7'b0, rex_b};
                    body[1] = OP_MOV_IMM64 | {5'b0, low};
                    for (int i = 0; i < 8; i++)
                    begin
                        body[2+i] = req.immediate[8*i +: 8];
                    end
                    body_len = 5'd10;
                end
            end
            REQ_FLD, REQ_FMUL, REQ_FADD, REQ_FSUB, REQ_FSTP:
            begin
                case (req.req_type)
                    REQ_FLD:  begin op = OP_FPU_DD; ext = EXT_FLD;  end
                    REQ_FMUL: begin op = OP_FPU_DC; ext = EXT_FMUL; end
                    REQ_FADD: begin op = OP_FPU_DC; ext = EXT_FADD; end
                    REQ_FSUB: begin op = OP_FPU_DC; ext = EXT_FSUB; end
                    default:  begin op = OP_FPU_DD; ext = EXT_FSTP; end
                endcase
                pre     = rex_b;
                body[0] = op;
                if (low == REG_LOW_SP)
                begin
                    body[1]  = MODRM_SIB | {2'b0, ext, 3'b0};
                    body[2]  = SIB_NO_INDEX;
                    body_len = 5'd3;
                end
                else if (low == REG_LOW_BP)
                begin
                    body[1]  = MODRM_DISP8 | {2'b0, ext, 3'b0};
                    body[2]  = DISP8_ZERO;
                    body_len = 5'd3;
                end
                else
                begin
                    body[1]  = {2'b0, ext, low};
                    body_len = 5'd2;
                end
            end
            REQ_FLD1:
            begin
                body[0]  = OP_FPU_D9;
                body[1]  = MODRM_FLD1;
                body_len = 5'd2;
            end
            REQ_FLDZ:
            begin
                body[0]  = OP_FPU_D9;
                body[1]  = MODRM_FLDZ;
                body_len = 5'd2;
            end
            REQ_PROLOGUE:
            begin
                cls.mode = MODE_PROLOGUE;
                body_len = PROLOGUE_LEN;
            end
            REQ_EPILOGUE:
            begin
                cls.mode = MODE_EPILOGUE;
                body_len = EPILOGUE_LEN;
            end
            default:
            begin
                body_len = '0;
            end
        endcase

        // optional REX.B prefix shifts the body up one byte
        cls.bytes[0] = pre ? OP_REX_B : body[0];
        for (int i = 1; i < LIST_BYTES; i++)
        begin
            cls.bytes[i] = pre ? body[i-1] : body[i];
        end
        cls.len = body_len + {{(CNT_W-1){1'b0}}, pre};
    end

    assign req.ready = !desc_valid_reg || desc_ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg;
        if (accept)
        begin
            desc_next       = cls;
            desc_valid_next = (cls.len != '0);
        end
        else if (desc_ready)
        begin
            desc_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign desc       = desc_reg;
    assign desc_valid = desc_valid_reg;

endmodule

// ===== src/x86enc_queue.sv =====
// Descriptor queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module x86enc_queue import x86enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_desc,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_Q-1:0] FULL_CNT = CNT_Q'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CNT_Q'(1);
            2'b01:   cnt_next = cnt_reg - CNT_Q'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/x86enc_back.sv =====
// Back end: steps through a descriptor and drives one code byte per beat.
`timescale 1ns / 1ps

module x86enc_back import x86enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  desc_t         head,
    input  logic          head_valid,
    output logic          head_pop,
    x86enc_beat_if.source rsp
);

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              last_reg;

    logic [BYTE_W-1:0] cur_byte;
    logic [CNT_W-1:0]  off;
    logic              is_last;
    logic              load;

    always_comb
    begin
        off = idx_reg - LOW_REG_COUNT;
        case (head.mode)
            MODE_LIST:
            begin
                cur_byte = head.bytes[idx_reg[3:0]];
            end
            MODE_PROLOGUE:
            begin
                // push rax..rdi, then REX.B + push for r8..r15
                if (idx_reg < LOW_REG_COUNT)
                    cur_byte = OP_PUSH | {5'b0, idx_reg[2:0]};
                else if (off[0])
                    cur_byte = OP_PUSH | {5'b0, off[3:1]};
                else
                    cur_byte = OP_REX_B;
            end
            MODE_EPILOGUE:
            begin
                // pop r15..r8 in pairs, then rdi..rax, then ret
                if (idx_reg < EPI_PAIR_END)
                    cur_byte = idx_reg[0] ? (OP_POP | {5'b0, ~idx_reg[3:1]}) : OP_REX_B;
                else if (idx_reg < EPI_RET_AT)
                    cur_byte = OP_POP | {5'b0, ~idx_reg[2:0]};
                else
                    cur_byte = OP_RET;
            end
            default:
            begin
                cur_byte = OP_RET;
            end
        endcase
    end

    assign is_last  = (idx_reg == head.len - CNT_W'(1));
    assign load     = head_valid && (!out_valid_reg || rsp.ready);
    assign head_pop = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? '0 : idx_reg + CNT_W'(1);
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= cur_byte;
            count_reg <= head.len;
            last_reg  <= is_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.code_byte  = byte_reg;
    assign rsp.byte_count = count_reg;
    assign rsp.last       = last_reg;

endmodule

// ===== src/x86_64_instruction_byte_encoder.sv =====
// x86-64 instruction byte encoder: top level.
// req channel: one beat names an instruction kind, reg_a, reg_b and a 64-bit
//   immediate. Kinds 19..31 are taken and produce no output beats.
// rsp channel: one beat per machine-code byte, in emission order, each with
//   the request's total byte_count and last set on its final byte.
// Path: the first byte of a request passes the classify register in the
//   front end, a queue entry and the output register of the back end, in
//   that order, before it is valid on rsp.
// Throughput: one output byte per cycle while rsp.ready is high, set by the
//   byte sequencer in the back end; a request gives byte_count bytes (1 to 10
//   for single instructions, 24 for the prologue, 25 for the epilogue), and
//   queued requests follow each other with no gap between their bytes.
// The request side stays ready while the descriptor queue (QUEUE_DEPTH
//   entries) has room, so new requests are taken while bytes stream out.
// When rsp.ready is low the current byte holds; the queue fills, and then
//   req.ready drops until bytes are taken again.
// Reset: rst_n is asynchronous, active low; all queues and the output
//   register empty at once, and no beat is pending after release.
`timescale 1ns / 1ps

module x86_64_instruction_byte_encoder import x86enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    x86enc_req_if.sink    req,
    x86enc_beat_if.source rsp
);

    desc_t front_desc;
    logic  front_valid;
    logic  front_ready;
    desc_t head_desc;
    logic  head_valid;
    logic  head_pop;

    x86enc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .desc       (front_desc),
        .desc_valid (front_valid),
        .desc_ready (front_ready)
    );

    x86enc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_desc  (front_desc),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_desc   (head_desc)
    );

    x86enc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_desc),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .rsp        (rsp)
    );

endmodule

// ===== src/x86enc_checker.sv =====
// Port-level checker for the x86-64 instruction byte encoder, with its bind.
`timescale 1ns / 1ps
`include "x86_64_instruction_byte_encoder_macros.svh"

module x86enc_checker import x86enc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [BYTE_W-1:0] code_byte,
    input logic [CNT_W-1:0]  byte_count,
    input logic              rsp_last
);

    logic [CNT_W-1:0] beat_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_idx_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            beat_idx_reg <= rsp_last ? '0 : beat_idx_reg + CNT_W'(1);
        end
    end

    `X86ENC_ASSERT_RST(a_reset_idle, !rsp_valid, "output beat pending in reset")
    `X86ENC_ASSERT_NXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(code_byte) && $stable(byte_count) && $stable(rsp_last), "stalled beat changed")
    `X86ENC_ASSERT_IMP(a_last_pos, rsp_valid, rsp_last == (beat_idx_reg + CNT_W'(1) == byte_count), "last does not match byte count")
    `X86ENC_ASSERT_IMP(a_count_range, rsp_valid, byte_count != '0 && byte_count <= CNT_W'(MAX_BYTES), "byte count out of range")
    `X86ENC_ASSERT_IMP(a_backpressure, !req_ready, rsp_valid, "request stalled with no output pending")

endmodule

bind x86_64_instruction_byte_encoder x86enc_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .code_byte  (rsp.code_byte),
    .byte_count (rsp.byte_count),
    .rsp_last   (rsp.last)
);
